>>> sv/ifa_pkg.sv
package ifa_pkg;

	localparam int unsigned DefWidth = 32;
	localparam int unsigned IoWidth = 32;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIVX = 5'd3, OP_QUO = 5'd4,
		OP_REM = 5'd5, OP_MOD = 5'd6, OP_MIN = 5'd7, OP_MAX = 5'd8, OP_AND = 5'd9,
		OP_OR = 5'd10, OP_XOR = 5'd11, OP_ASH = 5'd12, OP_LSH = 5'd13,
		OP_NOT = 5'd14, OP_ABS = 5'd15, OP_INC = 5'd16, OP_DEC = 5'd17,
		OP_LT = 5'd18, OP_LE = 5'd19, OP_EQ = 5'd20, OP_NE = 5'd21,
		OP_GE = 5'd22, OP_GT = 5'd23, OP_NEG = 5'd24, OP_ZERO = 5'd25,
		OP_POS = 5'd26, OP_EVEN = 5'd27, OP_ODD = 5'd28
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_INEXACT = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	typedef struct packed {
		logic [4:0] action;
		logic signed [IoWidth-1:0] operand;
		logic first;
		logic last;
	} in_beat_t;

	typedef struct packed {
		logic signed [IoWidth-1:0] value;
		logic [1:0] status;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic div_start;
		logic div_step;
		logic div_done;
		logic emit;
	} ifa_cmd_t;

	typedef struct packed {
		logic use_div;
		logic div_busy;
	} ifa_stat_t;

endpackage

>>> sv/ifa_ctrl.sv
module ifa_ctrl import ifa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_last,
	output logic out_valid,
	input logic out_ready,
	input ifa_stat_t stat,
	output ifa_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
	} state_t;

	state_t state_q;
	logic last_q;
	logic out_valid_q;
	logic take;
	logic fin_go;

	assign in_ready = state_q == S_IDLE;
	assign take = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign fin_go = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.load = take;
		case (state_q)
			S_EXEC: begin
				cmd.apply = !stat.use_div;
				cmd.div_start = stat.use_div;
			end
			S_DIV: begin
				cmd.div_step = stat.div_busy;
				cmd.div_done = !stat.div_busy;
			end
			S_FIN: cmd.emit = fin_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (take) begin
					last_q <= in_last;
					state_q <= S_EXEC;
				end
				S_EXEC: state_q <= stat.use_div ? S_DIV : (last_q ? S_FIN : S_IDLE);
				S_DIV: if (!stat.div_busy)
					state_q <= last_q ? S_FIN : S_IDLE;
				S_FIN: if (fin_go) begin
					out_valid_q <= 1'b1;
					last_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/ifa_dp.sv
module ifa_dp import ifa_pkg::*; #(
	parameter int unsigned WIDTH = DefWidth
) (
	input logic clk,
	input logic arst_n,
	input in_beat_t in_beat,
	input ifa_cmd_t cmd,
	output ifa_stat_t stat,
	output out_beat_t out_beat
);
	localparam int unsigned CW = $clog2(WIDTH + 1);
	localparam logic [WIDTH-1:0] Sign = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] Ones = '1;

	logic [WIDTH-1:0] acc_q, opnd_q, dvs_q, quo_q, rem_q;
	logic [4:0] op_q;
	logic [1:0] err_q;
	logic holds_q;
	logic [1:0] cnt_q;
	logic [CW-1:0] dcnt_q;
	out_beat_t out_q;

	logic [WIDTH-1:0] vin, b, a;
	logic [IoWidth-1:0] res_io;
	logic new_run;

	generate
		if (WIDTH >= IoWidth) begin : g_wide
			assign vin = WIDTH'($signed(in_beat.operand));
		end else begin : g_narrow
			assign vin = in_beat.operand[WIDTH-1:0];
		end
	endgenerate

	assign a = acc_q;
	assign b = opnd_q;
	assign new_run = in_beat.first || cnt_q == 2'd0;

	function automatic logic slt(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y);
		slt = (x ^ Sign) < (y ^ Sign);
	endfunction

	function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
		mag = x[WIDTH-1] ? (~x + 1'b1) : x;
	endfunction

	logic is_div;
	assign is_div = op_q == OP_DIVX || op_q == OP_QUO || op_q == OP_REM || op_q == OP_MOD;
	assign stat.use_div = is_div && err_q == ST_OK && b != '0;
	assign stat.div_busy = dcnt_q != '0;

	// Restoring divider on magnitudes, one quotient bit per cycle.
	logic [WIDTH:0] trial;
	assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dvs_q};

	logic [WIDTH-1:0] qs, rs, modv;
	assign qs = (a[WIDTH-1] != b[WIDTH-1]) ? (~quo_q + 1'b1) : quo_q;
	assign rs = a[WIDTH-1] ? (~rem_q + 1'b1) : rem_q;
	assign modv = (rs != '0 && a[WIDTH-1] != b[WIDTH-1]) ? rs + b : rs;

	logic [2*WIDTH-1:0] prod;
	assign prod = a * b;

	logic [WIDTH-1:0] m, shv;
	logic sh_ar;
	always_comb begin
		m = mag(b);
		sh_ar = op_q == OP_ASH;
		if (b[WIDTH-1]) begin
			if (m >= WIDTH)
				shv = sh_ar ? {WIDTH{a[WIDTH-1]}} : '0;
			else
				shv = sh_ar ? WIDTH'($signed(a) >>> m) : (a >> m);
		end else begin
			shv = (m >= WIDTH) ? '0 : (a << m);
		end
	end

	logic [WIDTH-1:0] acc_n;
	logic [1:0] err_n;
	logic holds_n, t;
	always_comb begin
		acc_n = acc_q;
		err_n = err_q;
		holds_n = holds_q;
		t = 1'b0;
		case (op_q)
			OP_ADD: acc_n = a + b;
			OP_SUB: acc_n = a - b;
			OP_MUL: acc_n = prod[WIDTH-1:0];
			OP_DIVX, OP_QUO, OP_REM, OP_MOD: err_n = ST_DIV0;
			OP_MIN: if (slt(b, a)) acc_n = b;
			OP_MAX: if (slt(a, b)) acc_n = b;
			OP_AND: acc_n = a & b;
			OP_OR: acc_n = a | b;
			OP_XOR: acc_n = a ^ b;
			OP_ASH, OP_LSH: begin
				if (cnt_q >= 2'd2) err_n = ST_COUNT;
				else acc_n = shv;
			end
			OP_NOT, OP_ABS, OP_INC, OP_DEC, OP_NEG, OP_ZERO, OP_POS, OP_EVEN, OP_ODD:
				err_n = ST_COUNT;
			OP_LT, OP_LE, OP_EQ, OP_NE, OP_GE, OP_GT: begin
				case (op_q)
					OP_LT: t = slt(a, b);
					OP_LE: t = !slt(b, a);
					OP_EQ: t = a == b;
					OP_NE: t = a != b;
					OP_GE: t = !slt(a, b);
					default: t = slt(b, a);
				endcase
				if (!t) holds_n = 1'b0;
				acc_n = b;
			end
			default: ;
		endcase
		if (err_q != ST_OK) begin
			acc_n = acc_q;
			err_n = err_q;
			holds_n = holds_q;
		end
	end

	logic [WIDTH-1:0] dres;
	logic dinexact;
	always_comb begin
		dinexact = 1'b0;
		case (op_q)
			OP_DIVX: begin
				dres = qs;
				dinexact = rs != '0;
			end
			OP_QUO: dres = qs;
			OP_REM: dres = rs;
			default: dres = modv;
		endcase
	end

	logic one;
	logic [WIDTH-1:0] fin;
	logic [1:0] ferr;
	assign one = cnt_q == 2'd1;
	always_comb begin
		fin = a;
		ferr = err_q;
		if (op_q == OP_SUB && one) begin
			fin = ~a + 1'b1;
		end else if (op_q == OP_DIVX && one) begin
			if (a == '0) ferr = ST_DIV0;
			else if (a != WIDTH'(1) && a != Ones) ferr = ST_INEXACT;
		end else if (op_q == OP_ASH || op_q == OP_LSH) begin
			if (cnt_q != 2'd2) ferr = ST_COUNT;
		end else if ((op_q >= OP_NOT && op_q <= OP_DEC) || (op_q >= OP_NEG && op_q <= OP_ODD)) begin
			if (!one) ferr = ST_COUNT;
			else begin
				case (op_q)
					OP_NOT: fin = ~a;
					OP_ABS: fin = mag(a);
					OP_INC: fin = a + 1'b1;
					OP_DEC: fin = a - 1'b1;
					OP_NEG: fin = WIDTH'(a[WIDTH-1]);
					OP_ZERO: fin = WIDTH'(a == '0);
					OP_POS: fin = WIDTH'(!a[WIDTH-1] && a != '0);
					OP_EVEN: fin = WIDTH'(!a[0]);
					default: fin = WIDTH'(a[0]);
				endcase
			end
		end else if (op_q >= OP_LT && op_q <= OP_GT) begin
			fin = WIDTH'(holds_q);
		end
		if (err_q != ST_OK) ferr = err_q;
		if (ferr != ST_OK) fin = '0;
	end

	generate
		if (WIDTH >= IoWidth) begin : g_ow
			assign res_io = fin[IoWidth-1:0];
		end else begin : g_on
			assign res_io = IoWidth'($signed(fin));
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			op_q <= '0;
			err_q <= ST_OK;
			holds_q <= 1'b1;
			cnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				opnd_q <= vin;
				if (new_run) begin
					acc_q <= vin;
					op_q <= in_beat.action;
					err_q <= ST_OK;
					holds_q <= 1'b1;
					cnt_q <= 2'd0;
				end
			end
			if (cmd.apply && cnt_q != 2'd0) begin
				acc_q <= acc_n;
				err_q <= err_n;
				holds_q <= holds_n;
			end
			if (cmd.apply || cmd.div_start)
				if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
			if (cmd.div_start) begin
				if (cnt_q == 2'd0) begin
					dcnt_q <= '0;
				end else begin
					quo_q <= mag(a);
					rem_q <= '0;
					dvs_q <= mag(b);
					dcnt_q <= CW'(WIDTH);
				end
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (!trial[WIDTH]) rem_q <= trial[WIDTH-1:0];
				else rem_q <= {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
				quo_q <= {quo_q[WIDTH-2:0], !trial[WIDTH]};
			end
			if (cmd.div_done && cnt_q >= 2'd2) begin
				if (dinexact) err_q <= ST_INEXACT;
				else acc_q <= dres;
			end
			if (cmd.emit) begin
				err_q <= ferr;
				cnt_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.value <= res_io;
			out_q.status <= ferr;
		end
	end

	assign out_beat = out_q;
endmodule

>>> sv/integer_fold_alu.sv
// Folds a run of signed operands under the operation named by the run's first beat; a
// result beat leaves on the beat marked last. A beat may feed the shared restoring divider
// for divide, quotient, remainder or modulo; the first beat of such a run passes through
// the divider state only when its operand is nonzero. A last beat also forms the result
// register and waits there for as long as an earlier result beat has not been taken.
module integer_fold_alu import ifa_pkg::*; #(
	parameter int unsigned WIDTH = DefWidth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data
);
	ifa_cmd_t cmd;
	ifa_stat_t stat;

	ifa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_last(in_data.last), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	ifa_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .cmd(cmd), .stat(stat),
		.out_beat(out_data)
	);
endmodule
